// File: rtl/core/assert_macros.svh
// Assertion macros used by the filter core controller, prf_ctrl.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: rtl/core/prf_pkg.sv
// Types and constants of the packet rule filter core.
// No dependencies.
package prf_pkg;
    localparam int ReqW = 2;
    localparam logic [1:0] REQ_LOCAL = 2'd0;
    localparam logic [1:0] REQ_PREROUTE = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [2:0] SEL_SIP = 3'd0;
    localparam logic [2:0] SEL_DIP = 3'd1;
    localparam logic [2:0] SEL_SPORT = 3'd2;
    localparam logic [2:0] SEL_DPORT = 3'd3;
    localparam logic [2:0] SEL_MAC = 3'd4;
    localparam logic [2:0] SEL_COMB = 3'd5;

    localparam logic [3:0] RSN_NONE = 4'd0;
    localparam logic [3:0] RSN_SIP = 4'd1;
    localparam logic [3:0] RSN_DIP = 4'd2;
    localparam logic [3:0] RSN_SPORT = 4'd3;
    localparam logic [3:0] RSN_DPORT = 4'd4;
    localparam logic [3:0] RSN_PING = 4'd5;
    localparam logic [3:0] RSN_HTTP = 4'd6;
    localparam logic [3:0] RSN_TELNET = 4'd7;
    localparam logic [3:0] RSN_BLOCKALL = 4'd8;
    localparam logic [3:0] RSN_MAC = 4'd9;
    localparam logic [3:0] RSN_COMB = 4'd10;

    localparam logic [2:0] CFG_FE = 3'd0;
    localparam logic [2:0] CFG_ACT_FROM = 3'd1;
    localparam logic [2:0] CFG_ACT_UNTIL = 3'd2;
    localparam logic [2:0] CFG_BA_FROM = 3'd3;
    localparam logic [2:0] CFG_BA_UNTIL = 3'd4;

    localparam int FE_ON = 0;
    localparam int FE_WINDOW = 1;
    localparam int FE_SIP = 2;
    localparam int FE_DIP = 3;
    localparam int FE_SPORT = 4;
    localparam int FE_DPORT = 5;
    localparam int FE_PING = 6;
    localparam int FE_HTTP = 7;
    localparam int FE_TELNET = 8;
    localparam int FE_BLOCKALL = 9;
    localparam int FE_MAC = 10;
    localparam int FE_COMB = 11;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [15:0] PORT_HTTP = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_HTTP_ALT = 16'd8080;
    localparam logic [15:0] PORT_TELNET = 16'd23;

    typedef struct packed {
        logic [4:0]  field_enables;
        logic        entry_valid;
        logic [3:0]  entry_index;
        logic [2:0]  table_select;
        logic [47:0] src_mac;
        logic [15:0] dport;
        logic [15:0] sport;
        logic [7:0]  ip_protocol;
        logic [31:0] dst_ip;
        logic [31:0] src_ip;
        logic [31:0] now_seconds;
        logic [1:0]  req_type;
    } item_t;

    typedef struct packed {
        logic [3:0] matched_entry;
        logic [3:0] drop_reason;
        logic       drop;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic eval;
    } cmd_t;
endpackage

// File: rtl/core/packet_rule_filter_core.sv
// Top level of the packet rule filter core: config registers, controller, datapath.
// Depends on prf_pkg, prf_ctrl, prf_datapath.
//
// channel  | signals                          | role
// s_axis   | tvalid tready tdata              | header or rule write word in
// m_axis   | tvalid tready tdata              | verdict word out
// cfg      | cfg_we cfg_index cfg_data        | register writes
//
// A word is accepted, matched against the registered lists in the next cycle
// into the verdict register, and offered the cycle after. The next word is
// accepted as the verdict leaves, not before. Reset clears the list valid bits
// and time registers at once and sets only the filter-on enable; no clearing pass.
module packet_rule_filter_core #(
    parameter int LIST_DEPTH = 16,
    parameter int COMBINED_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type, now_seconds, src_ip, dst_ip, ip_protocol, sport, dport,
    // src_mac, table_select, entry_index, entry_valid, field_enables, pad
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // drop, drop_reason, matched_entry, pad
    output logic [15:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import prf_pkg::*;

    logic [11:0] fe_reg;
    logic [31:0] act_from_reg, act_until_reg, ba_from_reg, ba_until_reg;
    cmd_t cmd;
    item_t item;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_reg <= 12'd1;
            act_from_reg <= '0;
            act_until_reg <= '0;
            ba_from_reg <= '0;
            ba_until_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FE: fe_reg <= cfg_data[11:0];
                CFG_ACT_FROM: act_from_reg <= cfg_data;
                CFG_ACT_UNTIL: act_until_reg <= cfg_data;
                CFG_BA_FROM: ba_from_reg <= cfg_data;
                CFG_BA_UNTIL: ba_until_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign item = item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    assign m_axis_tdata = {7'd0, res};

    prf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd)
    );

    prf_datapath #(.LIST_DEPTH(LIST_DEPTH), .COMBINED_DEPTH(COMBINED_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .item(item),
        .fe(fe_reg), .act_from(act_from_reg), .act_until(act_until_reg),
        .ba_from(ba_from_reg), .ba_until(ba_until_reg), .res(res)
    );
endmodule

// File: rtl/core/prf_datapath.sv
// Datapath: rule lists, combined rules and parallel match logic.
// Depends on prf_pkg.
module prf_datapath #(
    parameter int LIST_DEPTH = 16,
    parameter int COMBINED_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  prf_pkg::cmd_t     cmd,
    input  prf_pkg::item_t    item,
    input  logic [11:0]       fe,
    input  logic [31:0]       act_from,
    input  logic [31:0]       act_until,
    input  logic [31:0]       ba_from,
    input  logic [31:0]       ba_until,
    output prf_pkg::result_t  res
);
    import prf_pkg::*;

    item_t item_reg;
    logic [LIST_DEPTH-1:0] sip_v_reg, dip_v_reg, sp_v_reg, dp_v_reg, mac_v_reg;
    logic [31:0] sip_k_reg [LIST_DEPTH];
    logic [31:0] dip_k_reg [LIST_DEPTH];
    logic [15:0] sp_k_reg [LIST_DEPTH];
    logic [15:0] dp_k_reg [LIST_DEPTH];
    logic [47:0] mac_k_reg [LIST_DEPTH];
    logic [COMBINED_DEPTH-1:0] cv_reg;
    logic [4:0]  cf_reg [COMBINED_DEPTH];
    logic [31:0] csip_reg [COMBINED_DEPTH];
    logic [31:0] cdip_reg [COMBINED_DEPTH];
    logic [15:0] csp_reg [COMBINED_DEPTH];
    logic [15:0] cdp_reg [COMBINED_DEPTH];
    logic [47:0] cmac_reg [COMBINED_DEPTH];
    result_t res_reg, res_next;

    logic wr;
    assign wr = cmd.load && item.req_type == REQ_WRITE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sip_v_reg <= '0;
            dip_v_reg <= '0;
            sp_v_reg <= '0;
            dp_v_reg <= '0;
            mac_v_reg <= '0;
            cv_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                if (wr && 32'(item.entry_index) == i)
                begin
                    case (item.table_select)
                        SEL_SIP: sip_v_reg[i] <= item.entry_valid;
                        SEL_DIP: dip_v_reg[i] <= item.entry_valid;
                        SEL_SPORT: sp_v_reg[i] <= item.entry_valid;
                        SEL_DPORT: dp_v_reg[i] <= item.entry_valid;
                        SEL_MAC: mac_v_reg[i] <= item.entry_valid;
                        default: ;
                    endcase
                end
            end
            for (int i = 0; i < COMBINED_DEPTH; i++)
            begin
                if (wr && item.table_select == SEL_COMB && 32'(item.entry_index) == i)
                    cv_reg[i] <= item.entry_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (wr && 32'(item.entry_index) == i)
            begin
                case (item.table_select)
                    SEL_SIP: sip_k_reg[i] <= item.src_ip;
                    SEL_DIP: dip_k_reg[i] <= item.dst_ip;
                    SEL_SPORT: sp_k_reg[i] <= item.sport;
                    SEL_DPORT: dp_k_reg[i] <= item.dport;
                    SEL_MAC: mac_k_reg[i] <= item.src_mac;
                    default: ;
                endcase
            end
        end
        for (int i = 0; i < COMBINED_DEPTH; i++)
        begin
            if (wr && item.table_select == SEL_COMB && 32'(item.entry_index) == i)
            begin
                cf_reg[i] <= item.field_enables;
                csip_reg[i] <= item.src_ip;
                cdip_reg[i] <= item.dst_ip;
                csp_reg[i] <= item.sport;
                cdp_reg[i] <= item.dport;
                cmac_reg[i] <= item.src_mac;
            end
        end
        if (cmd.eval)
            res_reg <= res_next;
    end

    logic [LIST_DEPTH-1:0] sip_hit, dip_hit, sp_hit, dp_hit, mac_hit;
    logic [COMBINED_DEPTH-1:0] c_hit;
    logic l4, tcp;
    assign tcp = item_reg.ip_protocol == PROTO_TCP;
    assign l4 = tcp || item_reg.ip_protocol == PROTO_UDP;

    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            sip_hit[i] = sip_v_reg[i] && sip_k_reg[i] == item_reg.src_ip;
            dip_hit[i] = dip_v_reg[i] && dip_k_reg[i] == item_reg.dst_ip;
            sp_hit[i] = sp_v_reg[i] && sp_k_reg[i] == item_reg.sport && l4;
            dp_hit[i] = dp_v_reg[i] && dp_k_reg[i] == item_reg.dport && l4;
            mac_hit[i] = mac_v_reg[i] && mac_k_reg[i] == item_reg.src_mac;
        end
        for (int i = 0; i < COMBINED_DEPTH; i++)
        begin
            c_hit[i] = cv_reg[i]
                && (!cf_reg[i][0] || csip_reg[i] == item_reg.src_ip)
                && (!cf_reg[i][1] || cdip_reg[i] == item_reg.dst_ip)
                && (!cf_reg[i][2] || (l4 && csp_reg[i] == item_reg.sport))
                && (!cf_reg[i][3] || (l4 && cdp_reg[i] == item_reg.dport))
                && (!cf_reg[i][4] || cmac_reg[i] == item_reg.src_mac);
        end
    end

    function automatic logic [3:0] lowest_l(input logic [LIST_DEPTH-1:0] v);
        logic [3:0] r;
        r = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--)
            if (v[i])
                r = 4'(i);
        return r;
    endfunction

    function automatic logic [3:0] lowest_c(input logic [COMBINED_DEPTH-1:0] v);
        logic [3:0] r;
        r = '0;
        for (int i = COMBINED_DEPTH - 1; i >= 0; i--)
            if (v[i])
                r = 4'(i);
        return r;
    endfunction

    logic in_window, in_block, http;
    assign in_window = item_reg.now_seconds >= act_from && item_reg.now_seconds < act_until;
    assign in_block = ba_from <= item_reg.now_seconds && item_reg.now_seconds <= ba_until;
    assign http = item_reg.sport == PORT_HTTP || item_reg.sport == PORT_HTTPS
        || item_reg.sport == PORT_HTTP_ALT || item_reg.dport == PORT_HTTP
        || item_reg.dport == PORT_HTTPS || item_reg.dport == PORT_HTTP_ALT;

    always_comb
    begin
        res_next = '0;
        if (fe[FE_ON] && !(fe[FE_WINDOW] && !in_window))
        begin
            if (item_reg.req_type == REQ_LOCAL)
            begin
                if (fe[FE_SIP] && |sip_hit)
                    res_next = '{lowest_l(sip_hit), RSN_SIP, 1'b1};
                else if (fe[FE_DIP] && |dip_hit)
                    res_next = '{lowest_l(dip_hit), RSN_DIP, 1'b1};
                else if (fe[FE_SPORT] && |sp_hit)
                    res_next = '{lowest_l(sp_hit), RSN_SPORT, 1'b1};
                else if (fe[FE_DPORT] && |dp_hit)
                    res_next = '{lowest_l(dp_hit), RSN_DPORT, 1'b1};
                else if (fe[FE_PING] && item_reg.ip_protocol == PROTO_ICMP)
                    res_next = '{4'd0, RSN_PING, 1'b1};
                else if (fe[FE_HTTP] && tcp && http)
                    res_next = '{4'd0, RSN_HTTP, 1'b1};
                else if (fe[FE_TELNET] && tcp && item_reg.dport == PORT_TELNET)
                    res_next = '{4'd0, RSN_TELNET, 1'b1};
                else if (fe[FE_BLOCKALL] && in_block)
                    res_next = '{4'd0, RSN_BLOCKALL, 1'b1};
            end
            else if (item_reg.req_type == REQ_PREROUTE)
            begin
                if (fe[FE_MAC] && |mac_hit)
                    res_next = '{lowest_l(mac_hit), RSN_MAC, 1'b1};
                else if (fe[FE_COMB] && |c_hit)
                    res_next = '{lowest_c(c_hit), RSN_COMB, 1'b1};
            end
        end
    end

    assign res = res_reg;
endmodule

// File: rtl/core/prf_ctrl.sv
// Controller: input/output handshake and sequencing of the datapath.
// Depends on prf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module prf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output prf_pkg::cmd_t cmd
);
    import prf_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_OUT} state_t;
    state_t state_reg;

    // accept the next word in the cycle the result leaves, or while idle
    assign in_ready = state_reg == ST_IDLE || (state_reg == ST_OUT && out_ready);
    assign out_valid = state_reg == ST_OUT;
    assign cmd.load = in_valid && in_ready;
    assign cmd.eval = state_reg == ST_EVAL;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
        begin
            case (state_reg)
                ST_IDLE: if (in_valid) state_reg <= ST_EVAL;
                ST_EVAL: state_reg <= ST_OUT;
                ST_OUT:
                    if (out_ready)
                        state_reg <= in_valid ? ST_EVAL : ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_NEXT(a_load_eval, clk, rst_n, cmd.load, cmd.eval)
    `ASSERT_NEXT(a_eval_out, clk, rst_n, cmd.eval, out_valid)
    `ASSERT_IMPLIES(a_no_load_eval, clk, rst_n, cmd.eval, !in_ready)
endmodule

// File: sim/tb_top.sv
// Self-checking bench for packet_rule_filter_core: builds headers and rule writes,
// predicts each verdict word in SV and compares it field by field.
// Depends on prf_pkg and packet_rule_filter_core.
`timescale 1ns / 1ps

module tb_top;
    import prf_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [15:0]  m_axis_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    packet_rule_filter_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // filter state mirror
    logic [11:0] fe_reg;
    logic [31:0] act_from, act_until, ba_from, ba_until;
    logic        sip_v[16], dip_v[16], sport_v[16], dport_v[16], mac_v[16];
    logic [31:0] sip_k[16], dip_k[16];
    logic [15:0] sport_k[16], dport_k[16];
    logic [47:0] mac_k[16];
    logic        comb_v[16];
    logic [4:0]  comb_en[16];
    logic [31:0] comb_sip[16], comb_dip[16];
    logic [15:0] comb_sp[16], comb_dp[16];
    logic [47:0] comb_mac[16];

    result_t verdict_q[$];
    int      errors;
    int      send_idle_pct;
    int      recv_idle_pct;

    always
    begin
        clk = 1'b0; #10;
        clk = 1'b1; #10;
    end

    function automatic result_t verdict_of(logic d, logic [3:0] r, logic [3:0] e);
        result_t v;
        v.drop = d;
        v.drop_reason = r;
        v.matched_entry = e;
        return v;
    endfunction

    function automatic result_t classify(item_t it);
        logic l4;
        logic tcp;
        logic hit;
        tcp = it.ip_protocol == PROTO_TCP;
        l4 = tcp || it.ip_protocol == PROTO_UDP;
        if (it.req_type == REQ_WRITE)
        begin
            return verdict_of(1'b0, RSN_NONE, 4'd0);
        end
        if (it.req_type == 2'd3 || !fe_reg[FE_ON])
            return verdict_of(1'b0, RSN_NONE, 4'd0);
        if (fe_reg[FE_WINDOW] && (it.now_seconds < act_from || it.now_seconds >= act_until))
            return verdict_of(1'b0, RSN_NONE, 4'd0);
        if (it.req_type == REQ_LOCAL)
        begin
            if (fe_reg[FE_SIP])
                for (int i = 0; i < 16; i++)
                    if (sip_v[i] && sip_k[i] == it.src_ip)
                        return verdict_of(1'b1, RSN_SIP, 4'(i));
            if (fe_reg[FE_DIP])
                for (int i = 0; i < 16; i++)
                    if (dip_v[i] && dip_k[i] == it.dst_ip)
                        return verdict_of(1'b1, RSN_DIP, 4'(i));
            if (fe_reg[FE_SPORT] && l4)
                for (int i = 0; i < 16; i++)
                    if (sport_v[i] && sport_k[i] == it.sport)
                        return verdict_of(1'b1, RSN_SPORT, 4'(i));
            if (fe_reg[FE_DPORT] && l4)
                for (int i = 0; i < 16; i++)
                    if (dport_v[i] && dport_k[i] == it.dport)
                        return verdict_of(1'b1, RSN_DPORT, 4'(i));
            if (fe_reg[FE_PING] && it.ip_protocol == PROTO_ICMP)
                return verdict_of(1'b1, RSN_PING, 4'd0);
            if (fe_reg[FE_HTTP] && tcp &&
                (it.sport == PORT_HTTP || it.sport == PORT_HTTPS ||
                 it.sport == PORT_HTTP_ALT || it.dport == PORT_HTTP ||
                 it.dport == PORT_HTTPS || it.dport == PORT_HTTP_ALT))
                return verdict_of(1'b1, RSN_HTTP, 4'd0);
            if (fe_reg[FE_TELNET] && tcp && it.dport == PORT_TELNET)
                return verdict_of(1'b1, RSN_TELNET, 4'd0);
            if (fe_reg[FE_BLOCKALL] && ba_from <= it.now_seconds && it.now_seconds <= ba_until)
                return verdict_of(1'b1, RSN_BLOCKALL, 4'd0);
            return verdict_of(1'b0, RSN_NONE, 4'd0);
        end
        if (fe_reg[FE_MAC])
            for (int i = 0; i < 16; i++)
                if (mac_v[i] && mac_k[i] == it.src_mac)
                    return verdict_of(1'b1, RSN_MAC, 4'(i));
        if (fe_reg[FE_COMB])
            for (int i = 0; i < 16; i++)
            begin
                hit = comb_v[i];
                if (comb_en[i][0] && comb_sip[i] != it.src_ip) hit = 1'b0;
                if (comb_en[i][1] && comb_dip[i] != it.dst_ip) hit = 1'b0;
                if (comb_en[i][2] && (!l4 || comb_sp[i] != it.sport)) hit = 1'b0;
                if (comb_en[i][3] && (!l4 || comb_dp[i] != it.dport)) hit = 1'b0;
                if (comb_en[i][4] && comb_mac[i] != it.src_mac) hit = 1'b0;
                if (hit)
                    return verdict_of(1'b1, RSN_COMB, 4'(i));
            end
        return verdict_of(1'b0, RSN_NONE, 4'd0);
    endfunction

    task automatic load_rule(item_t it);
        int k;
        k = int'(it.entry_index);
        case (it.table_select)
            SEL_SIP:   begin sip_v[k] = it.entry_valid; sip_k[k] = it.src_ip; end
            SEL_DIP:   begin dip_v[k] = it.entry_valid; dip_k[k] = it.dst_ip; end
            SEL_SPORT: begin sport_v[k] = it.entry_valid; sport_k[k] = it.sport; end
            SEL_DPORT: begin dport_v[k] = it.entry_valid; dport_k[k] = it.dport; end
            SEL_MAC:   begin mac_v[k] = it.entry_valid; mac_k[k] = it.src_mac; end
            SEL_COMB:
            begin
                comb_v[k] = it.entry_valid;
                comb_en[k] = it.field_enables;
                comb_sip[k] = it.src_ip;
                comb_dip[k] = it.dst_ip;
                comb_sp[k] = it.sport;
                comb_dp[k] = it.dport;
                comb_mac[k] = it.src_mac;
            end
            default: ;
        endcase
    endtask

    task automatic send_word(item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        verdict_q.push_back(classify(it));
        if (it.req_type == REQ_WRITE)
            load_rule(it);
        s_axis_tdata <= {1'b0, it};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[8:0];
            if (verdict_q.size() == 0)
                report_mismatch("unexpected verdict", int'(got), 0);
            else
            begin
                want = verdict_q.pop_front();
                if (got.drop !== want.drop)
                    report_mismatch("drop", int'(got.drop), int'(want.drop));
                if (got.drop_reason !== want.drop_reason)
                    report_mismatch("drop_reason", int'(got.drop_reason),
                                    int'(want.drop_reason));
                if (got.matched_entry !== want.matched_entry)
                    report_mismatch("matched_entry", int'(got.matched_entry),
                                    int'(want.matched_entry));
            end
        end
    end

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_FE:        fe_reg = val[11:0];
            CFG_ACT_FROM:  act_from = val;
            CFG_ACT_UNTIL: act_until = val;
            CFG_BA_FROM:   ba_from = val;
            CFG_BA_UNTIL:  ba_until = val;
            default: ;
        endcase
    endtask

    // Small key pools so that packets hit loaded rules often
    function automatic item_t rand_header();
        item_t it;
        logic [223:0] r;
        logic [7:0] protos[4];
        logic [15:0] ports[6];
        protos = '{PROTO_ICMP, PROTO_TCP, PROTO_UDP, 8'd0};
        ports = '{PORT_HTTP, PORT_HTTPS, PORT_HTTP_ALT, PORT_TELNET, 16'd0, 16'hFFFF};
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = r[198:0];
        it.req_type = 2'($urandom_range(1));
        if ($urandom_range(3) != 0) it.src_ip = 32'hC0A8_0000 | $urandom_range(7);
        if ($urandom_range(3) != 0) it.dst_ip = 32'h0A00_0000 | $urandom_range(7);
        if ($urandom_range(3) != 0) it.sport = 16'($urandom_range(7));
        if ($urandom_range(2) == 0) it.sport = ports[$urandom_range(5)];
        if ($urandom_range(3) != 0) it.dport = 16'($urandom_range(7));
        if ($urandom_range(2) == 0) it.dport = ports[$urandom_range(5)];
        if ($urandom_range(3) != 0)
            it.src_mac = 48'h0200_0000_0000 | 48'($urandom_range(7));
        if ($urandom_range(3) != 0) it.ip_protocol = protos[$urandom_range(3)];
        if ($urandom_range(3) != 0) it.now_seconds = $urandom_range(1200);
        if ($urandom_range(19) == 0) it.req_type = 2'd3;
        return it;
    endfunction

    function automatic item_t rand_rule();
        item_t it;
        it = rand_header();
        it.req_type = REQ_WRITE;
        it.table_select = ($urandom_range(15) == 0) ? 3'($urandom_range(7))
                                                     : 3'($urandom_range(5));
        it.entry_index = 4'($urandom_range(15));
        it.entry_valid = ($urandom_range(3) != 0);
        return it;
    endfunction

    task automatic test_directed();
        item_t it;
        item_t proto_it;
        logic [7:0] protos[3];
        protos = '{PROTO_ICMP, PROTO_TCP, PROTO_UDP};
        proto_it = '0;
        proto_it.req_type = REQ_LOCAL;
        send_word(proto_it);                 // filter on, no rules
        write_reg(CFG_FE, 32'h0000_0FFF);
        write_reg(CFG_ACT_FROM, 32'd100);
        write_reg(CFG_ACT_UNTIL, 32'hFFFF_FFFF);
        write_reg(CFG_BA_FROM, 32'd1000);
        write_reg(CFG_BA_UNTIL, 32'hFFFF_FFFF);
        it = '1;
        it.req_type = REQ_WRITE;
        it.table_select = SEL_SIP;
        it.entry_valid = 1'b1;
        send_word(it);                       // all-ones keys at last entry
        it.table_select = SEL_MAC;
        send_word(it);
        it.table_select = SEL_COMB;
        it.field_enables = 5'd0;
        it.entry_index = 4'd3;               // rule with no fields matches all
        send_word(it);
        it.table_select = 3'd7;              // ignored target
        send_word(it);
        it = '1;
        it.req_type = REQ_LOCAL;
        send_word(it);
        it.req_type = REQ_PREROUTE;
        send_word(it);
        it.src_mac = 48'd5;
        send_word(it);                       // combined catch-all
        it.req_type = 2'd3;
        send_word(it);
        for (int i = 0; i < 3; i++)
        begin
            it = '0;
            it.req_type = REQ_LOCAL;
            it.now_seconds = 32'd500;
            it.ip_protocol = protos[i];
            it.dport = (i == 1) ? PORT_TELNET : PORT_HTTP;
            send_word(it);
        end
        it.now_seconds = 32'd50;             // outside active window
        send_word(it);
        it.now_seconds = 32'hFFFF_FFFF;
        it.ip_protocol = 8'd0;
        send_word(it);                       // in block-all range, but at window edge so outside active window
    endtask

    task automatic test_random(int n);
        item_t it;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                it = rand_rule();
            else
                it = rand_header();
            send_word(it);
        end
    endtask

    task automatic test_settings();
        logic [11:0] fes[4];
        fes = '{12'h000, 12'hFFD, 12'h001, 12'hFFF};
        for (int s = 0; s < 4; s++)
        begin
            write_reg(CFG_FE, 32'(fes[s]));
            write_reg(CFG_ACT_FROM, $urandom_range(300));
            write_reg(CFG_ACT_UNTIL, (s == 3) ? 32'd0 : 32'($urandom_range(600, 1300)));
            write_reg(CFG_BA_FROM, (s == 2) ? 32'd0 : 32'($urandom_range(900)));
            write_reg(CFG_BA_UNTIL, $urandom_range(1000, 1200));
            test_random(100);
        end
        write_reg(CFG_FE, $urandom_range(4095));
        test_random(100);
    endtask

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fe_reg = 12'd1;
        {act_from, act_until, ba_from, ba_until} = '0;
        for (int i = 0; i < 16; i++)
        begin
            {sip_v[i], dip_v[i], sport_v[i], dport_v[i], mac_v[i], comb_v[i]} = '0;
            comb_en[i] = '0;
        end
        send_idle_pct = 34;
        recv_idle_pct = 48;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random(600);
        drain();                             // hold off until all verdicts are out
        send_idle_pct = 48;
        recv_idle_pct = 34;
        test_settings();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(600);
        drain();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
